// ===== design/lbct_pkg.sv =====
// Shared types and constants for the LRU block cache tag controller.
// No dependencies; lbct_cell and the top level refer to it by scoped name.
`timescale 1ns / 1ps

package lbct_pkg;

    localparam int BLOCK_W           = 24;
    localparam int TOTAL_W           = 32;
    localparam int SLOT_OUT_W        = 4;
    localparam int CACHE_ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_FILL  = 2'd1,
        OP_WRITE = 2'd2,
        OP_CLEAR = 2'd3
    } lbct_op_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_MATCH   = 4'b0010,
        ST_RESOLVE = 4'b0100,
        ST_APPLY   = 4'b1000
    } lbct_state_t;

    typedef struct packed {
        logic clear;
        logic load;
    } lbct_cell_ctl_t;

endpackage

// ===== design/lbct_cell.sv =====
// One cell of the recency chain: holds the entry of one recency rank.
// Depends on lbct_pkg for the block width and the cell control struct.
`timescale 1ns / 1ps

module lbct_cell #(
    parameter int SLOT_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lbct_pkg::lbct_cell_ctl_t     ctl,
    input  logic [lbct_pkg::BLOCK_W-1:0] in_tag,
    input  logic [SLOT_W-1:0]            in_slot,
    input  logic                         in_valid,
    input  logic [lbct_pkg::BLOCK_W-1:0] cmp_tag,
    output logic [lbct_pkg::BLOCK_W-1:0] out_tag,
    output logic [SLOT_W-1:0]            out_slot,
    output logic                         out_valid,
    output logic                         match
);

    logic [lbct_pkg::BLOCK_W-1:0] tag_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic                         valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctl.load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            tag_reg  <= in_tag;
            slot_reg <= in_slot;
        end
    end

    assign match     = valid_reg && (tag_reg == cmp_tag);
    assign out_tag   = tag_reg;
    assign out_slot  = slot_reg;
    assign out_valid = valid_reg;

endmodule

// ===== design/lbct_match_enc.sv =====
// Encoder for the chain's match vector: hit flag, chain position and slot of the hit.
// Depends on lbct_pkg only through the house conventions; no package items used here.
`timescale 1ns / 1ps

module lbct_match_enc #(
    parameter int CACHE_ENTRIES = 16,
    parameter int SLOT_W        = 4
) (
    input  logic [CACHE_ENTRIES-1:0]             match,
    input  logic [CACHE_ENTRIES-1:0][SLOT_W-1:0] slots,
    output logic                                 hit,
    output logic [SLOT_W-1:0]                    pos,
    output logic [SLOT_W-1:0]                    slot
);

    always_comb begin
        pos  = '0;
        slot = '0;
        for (int j = 0; j < CACHE_ENTRIES; j++) begin
            pos  = pos  | ({SLOT_W{match[j]}} & SLOT_W'(j));
            slot = slot | ({SLOT_W{match[j]}} & slots[j]);
        end
    end

    assign hit = |match;

endmodule

// ===== design/lru_block_cache_tags.sv =====
// LRU block cache tag controller: top level with the recency chain and sequencer.
// Depends on lbct_pkg, lbct_cell and lbct_match_enc.
//
// Usage: a request beat on s_ (opcode, block_number) is taken when s_valid and
// s_ready are high; one result beat per request leaves on m_ (hit, slot, evicted,
// evicted_block, hit_total, access_total) under m_valid / m_ready.
// A request passes through the accepting IDLE state, MATCH for the parallel tag
// compare in every chain cell, RESOLVE to encode the match and APPLY to shift
// the chain and load the result register; APPLY waits while the output register
// is still full. No new request is taken until the previous one has left APPLY;
// the accept, compare, encode and shift steps and any stall in APPLY set that spacing.
// The chain holds entries in recency order, most recent in the first cell;
// a promotion or insertion shifts the leading cells by one place.
// A finished result sits in the output register; the next request may be
// accepted and processed while it waits, and its update is held until the
// output register is free, so a stalled receiver stalls the block.
// Reset (aresetn low, synchronous) empties the cache, zeroes both totals and
// drops any pending beat.
`timescale 1ns / 1ps

module lru_block_cache_tags #(
    parameter int CACHE_ENTRIES = lbct_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [lbct_pkg::BLOCK_W-1:0]        s_block_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [lbct_pkg::SLOT_OUT_W-1:0]     m_slot,
    output logic                                m_evicted,
    output logic [lbct_pkg::BLOCK_W-1:0]        m_evicted_block,
    output logic [lbct_pkg::TOTAL_W-1:0]        m_hit_total,
    output logic [lbct_pkg::TOTAL_W-1:0]        m_access_total
);

    localparam int SLOT_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int BW     = lbct_pkg::BLOCK_W;
    localparam int TW     = lbct_pkg::TOTAL_W;
    localparam int SOW    = lbct_pkg::SLOT_OUT_W;

    lbct_pkg::lbct_state_t state_reg, state_next;

    lbct_pkg::lbct_op_t    op_reg;
    logic [BW-1:0]         blk_reg;
    logic [CACHE_ENTRIES-1:0] match_reg;
    logic                  hit_reg;
    logic [SLOT_W-1:0]     pos_reg;
    logic [SLOT_W-1:0]     hslot_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TW-1:0]         hit_cnt_reg, hit_cnt_next;
    logic [TW-1:0]         acc_cnt_reg, acc_cnt_next;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [SOW-1:0]        m_slot_reg;
    logic                  m_evicted_reg;
    logic [BW-1:0]         m_evicted_block_reg;

    logic [CACHE_ENTRIES-1:0][BW-1:0]     cell_tag;
    logic [CACHE_ENTRIES-1:0][SLOT_W-1:0] cell_slot;
    logic [CACHE_ENTRIES-1:0]             cell_valid;
    logic [CACHE_ENTRIES-1:0]             cell_match;

    logic                  enc_hit;
    logic [SLOT_W-1:0]     enc_pos;
    logic [SLOT_W-1:0]     enc_slot;

    logic                  accept;
    logic                  commit;
    logic                  is_clear;
    logic                  is_read;
    logic                  full;
    logic                  do_update;
    logic                  do_evict;
    logic [SLOT_W-1:0]     shift_pos;
    logic [SLOT_W-1:0]     head_slot;
    logic [SLOT_W-1:0]     res_slot;
    logic [SLOT_W+SOW-1:0] res_slot_wide;

    assign s_ready = (state_reg == lbct_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == lbct_pkg::ST_APPLY) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbct_pkg::ST_IDLE: begin
                if (accept) state_next = lbct_pkg::ST_MATCH;
            end
            lbct_pkg::ST_MATCH:   state_next = lbct_pkg::ST_RESOLVE;
            lbct_pkg::ST_RESOLVE: state_next = lbct_pkg::ST_APPLY;
            lbct_pkg::ST_APPLY: begin
                if (commit) state_next = lbct_pkg::ST_IDLE;
            end
            default: state_next = lbct_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbct_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= lbct_pkg::lbct_op_t'(s_opcode);
            blk_reg <= s_block_number;
        end
        if (state_reg == lbct_pkg::ST_MATCH) begin
            match_reg <= cell_match;
        end
        if (state_reg == lbct_pkg::ST_RESOLVE) begin
            hit_reg   <= enc_hit;
            pos_reg   <= enc_pos;
            hslot_reg <= enc_slot;
        end
    end

    lbct_match_enc #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .SLOT_W        (SLOT_W)
    ) u_enc (
        .match (match_reg),
        .slots (cell_slot),
        .hit   (enc_hit),
        .pos   (enc_pos),
        .slot  (enc_slot)
    );

    // update decision
    assign is_clear  = (op_reg == lbct_pkg::OP_CLEAR);
    assign is_read   = (op_reg == lbct_pkg::OP_READ);
    assign full      = (count_reg == CNT_W'(CACHE_ENTRIES));
    assign do_update = !is_clear && (hit_reg || !is_read);
    assign do_evict  = !is_clear && !is_read && !hit_reg && full;
    assign shift_pos = hit_reg ? pos_reg : SLOT_W'(CACHE_ENTRIES - 1);

    always_comb begin
        if (hit_reg) begin
            head_slot = hslot_reg;
        end else if (full) begin
            head_slot = cell_slot[CACHE_ENTRIES-1];
        end else begin
            head_slot = count_reg[SLOT_W-1:0];
        end
    end

    assign res_slot      = (is_clear || (is_read && !hit_reg)) ? '0 : head_slot;
    assign res_slot_wide = {{SOW{1'b0}}, res_slot};

    // recency chain
    genvar j;
    generate
        for (j = 0; j < CACHE_ENTRIES; j++) begin : g_cell
            lbct_pkg::lbct_cell_ctl_t ctl;
            logic [BW-1:0]            in_tag;
            logic [SLOT_W-1:0]        in_slot;
            logic                     in_valid;

            assign ctl.clear = commit && is_clear;
            assign ctl.load  = commit && do_update && (shift_pos >= SLOT_W'(j));

            if (j == 0) begin : g_head
                assign in_tag   = blk_reg;
                assign in_slot  = head_slot;
                assign in_valid = 1'b1;
            end else begin : g_body
                assign in_tag   = cell_tag[j-1];
                assign in_slot  = cell_slot[j-1];
                assign in_valid = cell_valid[j-1];
            end

            lbct_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (ctl),
                .in_tag    (in_tag),
                .in_slot   (in_slot),
                .in_valid  (in_valid),
                .cmp_tag   (blk_reg),
                .out_tag   (cell_tag[j]),
                .out_slot  (cell_slot[j]),
                .out_valid (cell_valid[j]),
                .match     (cell_match[j])
            );
        end
    endgenerate

    // fill count and totals
    always_comb begin
        count_next   = count_reg;
        hit_cnt_next = hit_cnt_reg;
        acc_cnt_next = acc_cnt_reg;
        if (is_clear) begin
            count_next   = '0;
            hit_cnt_next = '0;
            acc_cnt_next = '0;
        end else begin
            if (do_update && !hit_reg && !full) begin
                count_next = count_reg + CNT_W'(1);
            end
            if (is_read) begin
                if (acc_cnt_reg != '1) acc_cnt_next = acc_cnt_reg + TW'(1);
                if (hit_reg && (hit_cnt_reg != '1)) hit_cnt_next = hit_cnt_reg + TW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            hit_cnt_reg <= '0;
            acc_cnt_reg <= '0;
        end else if (commit) begin
            count_reg   <= count_next;
            hit_cnt_reg <= hit_cnt_next;
            acc_cnt_reg <= acc_cnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_hit_reg           <= !is_clear && hit_reg;
            m_slot_reg          <= res_slot_wide[SOW-1:0];
            m_evicted_reg       <= do_evict;
            m_evicted_block_reg <= do_evict ? cell_tag[CACHE_ENTRIES-1] : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot          = m_slot_reg;
    assign m_evicted       = m_evicted_reg;
    assign m_evicted_block = m_evicted_block_reg;
    assign m_hit_total     = hit_cnt_reg;
    assign m_access_total  = acc_cnt_reg;

endmodule
